### design/pwq_pkg.sv
// Shared types and codes for the priority waiting queue.
package pwq_pkg;

    localparam int unsigned ID_W     = 16;
    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned LEVEL_W  = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FILL_W   = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TYPE_W-1:0]  code;
        logic [LEVEL_W-1:0] level;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_SHUP = 5'b00100,
        S_SHDN = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

endpackage

### design/priority_waiting_queue.sv
// Priority waiting queue: sorted entry table in a memory, walked by a sequencer.
//
// Requests arrive on in_valid/in_ready with func, entry_id, type_code and level.
// func insert adds an entry after all entries of equal or higher level, unless
// one with the same id and type code is already held; func remove deletes the
// first entry with a matching id and closes the gap. Each request gives one
// result on out_valid/out_ready: status and the table fill after the request.
// One request is handled at a time; in_ready is high only while idle.
// Steps, with n entries held: insert scans all n entries, then moves the entries
// from its insert position p upwards one place up, top first, and writes the new
// entry at p; remove scans up to the first match at a, then moves the entries
// above a one place down. A duplicate ends the scan at its match; a miss or a
// full table skips the shift.
// Reset empties the table at once (no clearing pass). While the receiver
// stalls the result is held and no new request is taken.
module priority_waiting_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [pwq_pkg::ID_W-1:0]      entry_id,
    input  logic [pwq_pkg::TYPE_W-1:0]    type_code,
    input  logic [pwq_pkg::LEVEL_W-1:0]   level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pwq_pkg::STATUS_W-1:0]  status,
    output logic [pwq_pkg::FILL_W-1:0]    fill
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    pwq_pkg::state_t state_reg, state_next;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pend_idx_reg, pend_idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic [pwq_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                         func_reg;
    logic [pwq_pkg::ID_W-1:0]     req_id_reg;
    logic [pwq_pkg::TYPE_W-1:0]   req_type_reg;
    logic [pwq_pkg::LEVEL_W-1:0]  req_level_reg;

    pwq_pkg::entry_t mem [QUEUE_DEPTH];
    pwq_pkg::entry_t rd_data_reg;
    pwq_pkg::entry_t wr_data;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;

    logic            accept;
    logic            issue_scan;
    logic            issue_shift;
    logic [CW-1:0]   ins_pos;

    assign in_ready  = (state_reg == pwq_pkg::S_IDLE);
    assign out_valid = (state_reg == pwq_pkg::S_RESP);
    assign status    = status_reg;
    assign fill      = pwq_pkg::FILL_W'(occ_reg);

    assign accept      = in_valid && in_ready;
    assign issue_scan  = (idx_reg < occ_reg);
    assign issue_shift = (cnt_reg != '0);
    assign rd_addr     = idx_reg[AW-1:0];
    assign ins_pos     = found_reg ? pos_reg : occ_reg;

    // Table memory: one write, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Request fields, captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= func;
            req_id_reg    <= entry_id;
            req_type_reg  <= type_code;
            req_level_reg <= level;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        occ_next      = occ_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg[AW-1:0];
        wr_data       = rd_data_reg;

        case (state_reg)
            pwq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    state_next = pwq_pkg::S_SCAN;
                end
            end

            pwq_pkg::S_SCAN:
            begin
                // Issue the next read while checking the entry read last cycle.
                pend_next     = issue_scan;
                pend_idx_next = idx_reg;
                if (issue_scan)
                begin
                    idx_next = idx_reg + ONE_C;
                end
                if (pend_reg)
                begin
                    if (func_reg == pwq_pkg::FUNC_INSERT)
                    begin
                        if (rd_data_reg.id == req_id_reg && rd_data_reg.code == req_type_reg)
                        begin
                            status_next = pwq_pkg::ST_DUPLICATE;
                            pend_next   = 1'b0;
                            state_next  = pwq_pkg::S_RESP;
                        end
                        else if (!found_reg && rd_data_reg.level < req_level_reg)
                        begin
                            found_next = 1'b1;
                            pos_next   = pend_idx_reg;
                        end
                    end
                    else if (rd_data_reg.id == req_id_reg)
                    begin
                        // Close the gap from the match upwards.
                        cnt_next   = occ_reg - ONE_C - pend_idx_reg;
                        idx_next   = pend_idx_reg + ONE_C;
                        pend_next  = 1'b0;
                        state_next = pwq_pkg::S_SHDN;
                    end
                end
                else if (!issue_scan)
                begin
                    if (func_reg == pwq_pkg::FUNC_INSERT)
                    begin
                        if (occ_reg >= DEPTH_C)
                        begin
                            status_next = pwq_pkg::ST_FULL;
                            state_next  = pwq_pkg::S_RESP;
                        end
                        else
                        begin
                            pos_next   = ins_pos;
                            cnt_next   = occ_reg - ins_pos;
                            idx_next   = occ_reg - ONE_C;
                            state_next = pwq_pkg::S_SHUP;
                        end
                    end
                    else
                    begin
                        status_next = pwq_pkg::ST_NOT_FOUND;
                        state_next  = pwq_pkg::S_RESP;
                    end
                end
            end

            pwq_pkg::S_SHUP:
            begin
                // Move entries one place up, top first, then drop the new one in.
                pend_next     = issue_shift;
                pend_idx_next = idx_reg;
                if (issue_shift)
                begin
                    idx_next = idx_reg - ONE_C;
                    cnt_next = cnt_reg - ONE_C;
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(pend_idx_reg + ONE_C);
                end
                else if (!issue_shift)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pos_reg[AW-1:0];
                    wr_data.id    = req_id_reg;
                    wr_data.code  = req_type_reg;
                    wr_data.level = req_level_reg;
                    occ_next      = occ_reg + ONE_C;
                    status_next   = pwq_pkg::ST_INSERTED;
                    state_next    = pwq_pkg::S_RESP;
                end
            end

            pwq_pkg::S_SHDN:
            begin
                pend_next     = issue_shift;
                pend_idx_next = idx_reg;
                if (issue_shift)
                begin
                    idx_next = idx_reg + ONE_C;
                    cnt_next = cnt_reg - ONE_C;
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(pend_idx_reg - ONE_C);
                end
                else if (!issue_shift)
                begin
                    occ_next    = occ_reg - ONE_C;
                    status_next = pwq_pkg::ST_REMOVED;
                    state_next  = pwq_pkg::S_RESP;
                end
            end

            pwq_pkg::S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = pwq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pwq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pwq_pkg::S_IDLE;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            found_reg    <= 1'b0;
            pos_reg      <= '0;
            occ_reg      <= '0;
            status_reg   <= pwq_pkg::ST_INSERTED;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            found_reg    <= found_next;
            pos_reg      <= pos_next;
            occ_reg      <= occ_next;
            status_reg   <= status_next;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_C)
        else $error("occupancy beyond table depth");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while a result is pending");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |-> $past(state_reg == pwq_pkg::S_SHUP
            || state_reg == pwq_pkg::S_SHDN))
        else $error("occupancy changed outside a shift");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready || out_valid) |-> !wr_en)
        else $error("table written while idle or responding");

endmodule
